### sv/gld_pkg.sv
// Shared constants, register codes and item types for the grid local maximum detector.
`timescale 1ns / 1ps
`default_nettype none

package gld_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;

  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int SIZE_BITS      = 11;
  localparam int THRESHOLD_BITS = 16;
  localparam int TOLERANCE_BITS = 15;
  localparam int COORD_BITS     = 10;
  localparam int TOTAL_BITS     = 21;
  localparam int RESULTS_MAX    = 4;

  localparam int MIN_SIZE        = 3;
  localparam int SIZE_RESET      = 256;
  localparam int THRESHOLD_RESET = 0;
  localparam int TOLERANCE_RESET = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_CREST_THRESHOLD = 2'd2,
    REG_PEAK_TOLERANCE  = 2'd3
  } cfg_reg_t;

  // Position flags of a sample, worked out when the item is taken in.
  typedef struct packed {
    logic valid;
    logic x_zero;
    logic x_one;
    logic y_zero;
    logic y_one;
    logic last_col;
    logic last_row;
  } pos_flags_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  done;
    logic [TOTAL_BITS-1:0] total;
  } result_t;

  // All results caused by one sample, in delivery order from entry 0.
  typedef struct packed {
    logic [RESULTS_MAX-1:0]         mask;
    result_t [RESULTS_MAX-1:0]      entry;
  } bundle_t;

endpackage

`default_nettype wire

### sv/gld_sample_if.sv
// Sample channel: valid, ready and one elevation sample per item.
`timescale 1ns / 1ps
`default_nettype none

interface gld_sample_if #(
  parameter int SAMPLE_BITS = gld_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

### sv/gld_result_if.sv
// Result channel: valid, ready and one peak or closing record per item.
`timescale 1ns / 1ps
`default_nettype none

interface gld_result_if;
  logic                            valid;
  logic                            ready;
  logic [gld_pkg::COORD_BITS-1:0]  peak_x;
  logic [gld_pkg::COORD_BITS-1:0]  peak_y;
  logic                            frame_done;
  logic [gld_pkg::TOTAL_BITS-1:0]  peak_total;
  logic                            last_of_run;

  modport source (output valid, output peak_x, output peak_y, output frame_done,
                  output peak_total, output last_of_run, input ready);
  modport sink (input valid, input peak_x, input peak_y, input frame_done,
                input peak_total, input last_of_run, output ready);
endinterface

`default_nettype wire

### sv/gld_line_store.sv
// Single-port-write, registered-read memory holding the two previous sample rows.
`timescale 1ns / 1ps
`default_nettype none

module gld_line_store #(
  parameter int DEPTH = gld_pkg::MAX_WIDTH_DEF,
  parameter int WIDTH = 2 * gld_pkg::SAMPLE_BITS_DEF,
  parameter int AW    = $clog2(gld_pkg::MAX_WIDTH_DEF)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/gld_judge.sv
// 3x3 window registers and the peak decisions for the cells completed by each sample.
`timescale 1ns / 1ps
`default_nettype none

module gld_judge #(
  parameter int SAMPLE_BITS = gld_pkg::SAMPLE_BITS_DEF,
  parameter int XW          = $clog2(gld_pkg::MAX_WIDTH_DEF),
  parameter int YW          = $clog2(gld_pkg::MAX_HEIGHT_DEF)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  adv,
  input  wire logic                                  clear,
  input  wire gld_pkg::pos_flags_t                   b_flags,
  input  wire logic [XW-1:0]                         b_x,
  input  wire logic [YW-1:0]                         b_y,
  input  wire logic [SAMPLE_BITS-1:0]                b_sample,
  input  wire logic [SAMPLE_BITS-1:0]                up1,
  input  wire logic [SAMPLE_BITS-1:0]                up2,
  input  wire logic [XW-1:0]                         w_last,
  input  wire logic [YW-1:0]                         h_last,
  input  wire logic [gld_pkg::THRESHOLD_BITS-1:0]    threshold,
  input  wire logic [gld_pkg::TOLERANCE_BITS-1:0]    tolerance,
  output      gld_pkg::bundle_t                      bundle
);

  localparam int S  = SAMPLE_BITS;
  localparam int DW = ((S + 1 > gld_pkg::THRESHOLD_BITS) ? S + 1 : gld_pkg::THRESHOLD_BITS) + 1;
  localparam int TB = gld_pkg::TOTAL_BITS;
  localparam int CB = gld_pkg::COORD_BITS;

  gld_pkg::pos_flags_t c_flags;
  logic [XW-1:0]       c_x;
  logic [YW-1:0]       c_y;
  logic [S-1:0]        win [9];
  logic [TB-1:0]       count;
  logic [TB-1:0]       count_next;

  logic signed [DW-1:0] tol_x;
  logic signed [DW-1:0] thr_x;
  logic [8:0]           ok1;
  logic [8:0]           ok2;
  logic [8:0]           ok3;
  logic                 p1;
  logic                 p2;
  logic                 p3;
  logic                 done;
  logic [TB-1:0]        t1;
  logic [TB-1:0]        t2;
  logic [TB-1:0]        t3;
  logic [XW-1:0]        cx_m1;
  logic [YW-1:0]        cy_m1;

  function automatic logic signed [DW-1:0] widen(input logic [S-1:0] v);
    return $signed({{(DW - S){v[S-1]}}, v});
  endfunction

  assign tol_x = $signed({{(DW - gld_pkg::TOLERANCE_BITS){1'b0}}, tolerance});
  assign thr_x = $signed({{(DW - gld_pkg::THRESHOLD_BITS){threshold[gld_pkg::THRESHOLD_BITS-1]}},
                          threshold});

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ok1[k] = (widen(win[k]) - widen(win[4])) <= tol_x;
      ok2[k] = (widen(win[k]) - widen(win[5])) <= tol_x;
      ok3[k] = (widen(win[k]) - widen(win[7])) <= tol_x;
    end
  end

  always_comb begin
    p1 = c_flags.valid && !c_flags.x_zero && !c_flags.y_zero
         && !(c_flags.x_one && c_flags.y_one) && (widen(win[4]) > thr_x);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0) && c_flags.y_one) && !((c == 0) && c_flags.x_one)) begin
          p1 = p1 && ok1[r * 3 + c];
        end
      end
    end
    p2 = c_flags.valid && !c_flags.y_zero && c_flags.last_col && !c_flags.y_one
         && (widen(win[5]) > thr_x)
         && ok2[1] && ok2[2] && ok2[4] && ok2[5] && ok2[7] && ok2[8];
    p3 = c_flags.valid && c_flags.last_row && !c_flags.x_zero && !c_flags.x_one
         && (widen(win[7]) > thr_x)
         && ok3[3] && ok3[4] && ok3[5] && ok3[6] && ok3[7] && ok3[8];
    done = c_flags.valid && c_flags.last_col && c_flags.last_row;
  end

  assign t1    = count + TB'(p1);
  assign t2    = t1 + TB'(p2);
  assign t3    = t2 + TB'(p3);
  assign cx_m1 = c_x - 1'b1;
  assign cy_m1 = c_y - 1'b1;
  assign count_next = done ? '0 : t3;

  always_comb begin
    bundle.mask           = {done, p3, p2, p1};
    bundle.entry[0].x     = CB'(cx_m1);
    bundle.entry[0].y     = CB'(cy_m1);
    bundle.entry[0].done  = 1'b0;
    bundle.entry[0].total = t1;
    bundle.entry[1].x     = CB'(w_last);
    bundle.entry[1].y     = CB'(cy_m1);
    bundle.entry[1].done  = 1'b0;
    bundle.entry[1].total = t2;
    bundle.entry[2].x     = CB'(cx_m1);
    bundle.entry[2].y     = CB'(h_last);
    bundle.entry[2].done  = 1'b0;
    bundle.entry[2].total = t3;
    bundle.entry[3].x     = '0;
    bundle.entry[3].y     = '0;
    bundle.entry[3].done  = 1'b1;
    bundle.entry[3].total = t3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_flags <= '0;
      count   <= '0;
    end else begin
      if (adv) begin
        c_flags <= b_flags;
      end
      if (clear) begin
        count <= '0;
      end else if (adv && c_flags.valid) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_flags.valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r * 3]     <= win[r * 3 + 1];
        win[r * 3 + 1] <= win[r * 3 + 2];
      end
      win[2] <= up2;
      win[5] <= up1;
      win[8] <= b_sample;
      c_x    <= b_x;
      c_y    <= b_y;
    end
  end

endmodule

`default_nettype wire

### sv/gld_serializer.sv
// Holds one sample's results and sends them one item per cycle while ready, via an output register.
`timescale 1ns / 1ps
`default_nettype none

module gld_serializer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gld_pkg::bundle_t  bundle,
  output      logic              adv,
  gld_result_if.source           peaks
);

  localparam int RM = gld_pkg::RESULTS_MAX;

  logic [RM-1:0]                 pend;
  gld_pkg::result_t [RM-1:0]     slot;
  gld_pkg::result_t              o_res;
  logic                          o_last;
  logic                          o_valid;
  logic                          out_load;
  logic [RM-1:0]                 pick;
  logic [RM-1:0]                 rest;
  gld_pkg::result_t              sel;

  assign out_load = !o_valid || peaks.ready;
  assign pick     = pend & (~pend + 1'b1);
  assign rest     = pend & ~pick;
  assign adv      = (pend == '0) || ((rest == '0) && out_load);

  always_comb begin
    sel = '0;
    for (int i = 0; i < RM; i++) begin
      if (pick[i]) begin
        sel = slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (out_load) begin
        o_valid <= (pend != '0);
      end
      if (adv) begin
        pend <= bundle.mask;
      end else if (out_load) begin
        pend <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && (pend != '0)) begin
      o_res  <= sel;
      o_last <= (rest == '0);
    end
    if (adv) begin
      slot <= bundle.entry;
    end
  end

  assign peaks.valid       = o_valid;
  assign peaks.peak_x      = o_res.x;
  assign peaks.peak_y      = o_res.y;
  assign peaks.frame_done  = o_res.done;
  assign peaks.peak_total  = o_res.total;
  assign peaks.last_of_run = o_last;

endmodule

`default_nettype wire

### sv/grid_local_maximum_detector.sv
// Top level of the grid local maximum detector: registers, raster position and line store.
`timescale 1ns / 1ps
`default_nettype none

// Takes one elevation sample per clock in raster order while not stalled and reports each
// 3x3 (or 2x3 on an edge) local maximum away from the frame corners as soon as its
// neighbourhood has arrived, followed after the last sample of a frame by a closing
// record with the frame's peak count. A sample passes through an input stage with a
// registered line-store read, the window and decision stage, and a result slot with an
// output register. Samples are taken every cycle while results leave no faster than
// they are made; a sample causing k results keeps the output busy until all k have
// left, and the input stalls while the result slot still holds more than one item, or
// holds one that the output register cannot yet take because its item is waiting.
// Width and height writes restart the frame and must be made while the block is idle.
module grid_local_maximum_detector #(
  parameter int MAX_WIDTH   = gld_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = gld_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = gld_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [gld_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  wire logic [gld_pkg::CFG_BITS-1:0]        wr_data,
  gld_sample_if.sink                               samples,
  gld_result_if.source                             peaks
);

  localparam int S  = SAMPLE_BITS;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int SB = gld_pkg::SIZE_BITS;
  localparam logic [XW-1:0] W_LAST_RESET =
    XW'(((gld_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : gld_pkg::SIZE_RESET) - 1);
  localparam logic [YW-1:0] H_LAST_RESET =
    YW'(((gld_pkg::SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : gld_pkg::SIZE_RESET) - 1);

  logic [XW-1:0]                         w_last;
  logic [YW-1:0]                         h_last;
  logic [gld_pkg::THRESHOLD_BITS-1:0]    threshold;
  logic [gld_pkg::TOLERANCE_BITS-1:0]    tolerance;
  logic [XW-1:0]                         x;
  logic [YW-1:0]                         y;
  logic [SB-1:0]                         size_raw;
  logic [XW-1:0]                         w_set;
  logic [YW-1:0]                         h_set;
  logic                                  size_wr;
  logic                                  adv;
  logic                                  in_fire;
  gld_pkg::pos_flags_t                   flags;
  gld_pkg::pos_flags_t                   b_flags;
  logic [XW-1:0]                         b_x;
  logic [YW-1:0]                         b_y;
  logic [S-1:0]                          b_sample;
  logic [2*S-1:0]                        line_rd;
  gld_pkg::bundle_t                      bundle;

  assign size_raw = wr_data[SB-1:0];
  assign size_wr  = wr_en && ((gld_pkg::cfg_reg_t'(wr_index) == gld_pkg::REG_FRAME_WIDTH)
                           || (gld_pkg::cfg_reg_t'(wr_index) == gld_pkg::REG_FRAME_HEIGHT));

  always_comb begin
    if (int'(size_raw) < gld_pkg::MIN_SIZE) begin
      w_set = XW'(gld_pkg::MIN_SIZE - 1);
      h_set = YW'(gld_pkg::MIN_SIZE - 1);
    end else begin
      w_set = (int'(size_raw) > MAX_WIDTH) ? XW'(MAX_WIDTH - 1) : XW'(size_raw - 1'b1);
      h_set = (int'(size_raw) > MAX_HEIGHT) ? YW'(MAX_HEIGHT - 1) : YW'(size_raw - 1'b1);
    end
  end

  assign in_fire       = samples.valid && adv;
  assign samples.ready = adv;

  always_comb begin
    flags.valid    = 1'b1;
    flags.x_zero   = (x == '0);
    flags.x_one    = (x == XW'(1));
    flags.y_zero   = (y == '0);
    flags.y_one    = (y == YW'(1));
    flags.last_col = (x == w_last);
    flags.last_row = (y == h_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last    <= W_LAST_RESET;
      h_last    <= H_LAST_RESET;
      threshold <= gld_pkg::THRESHOLD_BITS'(gld_pkg::THRESHOLD_RESET);
      tolerance <= gld_pkg::TOLERANCE_BITS'(gld_pkg::TOLERANCE_RESET);
      x         <= '0;
      y         <= '0;
      b_flags   <= '0;
    end else begin
      if (wr_en) begin
        case (gld_pkg::cfg_reg_t'(wr_index))
          gld_pkg::REG_FRAME_WIDTH: begin
            w_last <= w_set;
            x      <= '0;
            y      <= '0;
          end
          gld_pkg::REG_FRAME_HEIGHT: begin
            h_last <= h_set;
            x      <= '0;
            y      <= '0;
          end
          gld_pkg::REG_CREST_THRESHOLD: begin
            threshold <= wr_data[gld_pkg::THRESHOLD_BITS-1:0];
          end
          gld_pkg::REG_PEAK_TOLERANCE: begin
            tolerance <= wr_data[gld_pkg::TOLERANCE_BITS-1:0];
          end
          default: begin
          end
        endcase
      end else if (in_fire) begin
        if (flags.last_col) begin
          x <= '0;
          y <= flags.last_row ? '0 : y + 1'b1;
        end else begin
          x <= x + 1'b1;
        end
      end
      if (adv) begin
        b_flags <= in_fire ? flags : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_x      <= x;
      b_y      <= y;
      b_sample <= samples.sample;
    end
  end

  gld_line_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * S),
    .AW    (XW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (x),
    .rd_data (line_rd),
    .wr_en   (adv && b_flags.valid),
    .wr_addr (b_x),
    .wr_data ({b_sample, line_rd[2*S-1:S]})
  );

  gld_judge #(
    .SAMPLE_BITS (S),
    .XW          (XW),
    .YW          (YW)
  ) u_judge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .clear     (size_wr),
    .b_flags   (b_flags),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_sample  (b_sample),
    .up1       (line_rd[2*S-1:S]),
    .up2       (line_rd[S-1:0]),
    .w_last    (w_last),
    .h_last    (h_last),
    .threshold (threshold),
    .tolerance (tolerance),
    .bundle    (bundle)
  );

  gld_serializer u_serializer (
    .clk    (clk),
    .rst    (rst),
    .bundle (bundle),
    .adv    (adv),
    .peaks  (peaks)
  );

endmodule

`default_nettype wire
